[sv/vmb_pkg.sv]
// Shared types, constants and rounding helpers for the view matrix builder.
package vmb_pkg;

    // Axis entries carry 30 fraction bits (Q2.30).
    localparam int AXIS_FRAC_BITS = 30;

    typedef logic signed [31:0] word_t;
    typedef logic signed [32:0] diff_t;
    typedef logic signed [63:0] wide_t;
    typedef logic signed [65:0] acc_t;

    // Three-entry vectors, entry 0 is x.
    typedef word_t [2:0] vec_t;
    typedef diff_t [2:0] dvec_t;
    typedef wide_t [2:0] wvec_t;

    // One classified request as it travels from the front part to the back part.
    typedef struct packed {
        vec_t  eye;
        vec_t  hint;
        dvec_t diff;
        logic  degenerate;
    } job_t;

    // Add one half, shift right 30 with floor and saturate to 32 bits.
    function automatic word_t round_sat(input acc_t v);
        logic signed [66:0] biased;
        logic signed [36:0] shifted;
        biased  = 67'(v) + 67'sd536870912;
        shifted = biased[66:30];
        if (shifted > 37'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (shifted < -37'sd2147483648)
            return 32'sh80000000;
        else
            return shifted[31:0];
    endfunction

endpackage

[sv/vmb_front.sv]
// Front part: takes requests, forms eye minus target and flags a degenerate view.
module vmb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [287:0]      s_tdata,
    output logic              push,
    output vmb_pkg::job_t     push_data,
    input  logic              q_ready
);

    logic          in_valid_reg;
    logic          in_valid_next;
    vmb_pkg::job_t job_reg;
    vmb_pkg::job_t job_next;
    logic          accept;

    // The holding register frees up whenever its request moves into the queue.
    assign s_tready  = !in_valid_reg || q_ready;
    assign accept    = s_tvalid && s_tready;
    assign push      = in_valid_reg && q_ready;
    assign push_data = job_reg;

    // Unpack the fields and form the exact 33-bit difference.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            job_next.eye[i]  = s_tdata[32*i +: 32];
            job_next.hint[i] = s_tdata[192 + 32*i +: 32];
            job_next.diff[i] = $signed({s_tdata[32*i + 31], s_tdata[32*i +: 32]})
                             - $signed({s_tdata[96 + 32*i + 31], s_tdata[96 + 32*i +: 32]});
        end
        job_next.degenerate = (job_next.diff[0] == '0) && (job_next.diff[1] == '0)
                           && (job_next.diff[2] == '0);
    end

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (push)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_next;
    end

endmodule

[sv/vmb_queue.sv]
// Two-entry request queue between the front part and the back part.
module vmb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vmb_pkg::job_t push_data,
    output logic          q_ready,
    input  logic          pop,
    output logic          q_valid,
    output vmb_pkg::job_t pop_data
);

    localparam int DEPTH = 2;

    vmb_pkg::job_t mem [DEPTH];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign q_ready  = (count_reg != 2'(DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

[sv/vmb_norm.sv]
// Normalize unit: scales a vector, sums squares, takes a bit-serial root and divides.
module vmb_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  vmb_pkg::wvec_t vec_in,
    output logic           done,
    output vmb_pkg::vec_t  unit_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SQUARE,
        ST_ROOT,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t      state_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] mag_reg  [3];
    logic [2:0]  neg_reg;
    logic [61:0] prod_reg;
    logic [63:0] sum_reg;
    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [31:0] part_reg [3];
    logic [30:0] nlo_reg  [3];
    logic [30:0] quo_reg  [3];

    logic [63:0] mag_or;
    logic [30:0] sq_src;
    logic [63:0] root_try;
    logic [61:0] div_num  [3];
    logic [32:0] div_shift [3];
    logic [32:0] div_sub  [3];
    logic [2:0]  div_ge;
    logic [32:0] divisor;

    assign mag_or   = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign root_try = root_reg + bit_reg;
    assign divisor  = {1'b0, root_reg[31:0]};
    assign done     = (state_reg == ST_DONE);

    // Operand of the squaring multiplier.
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    sq_src = mag_reg[0][30:0];
            2'd1:    sq_src = mag_reg[1][30:0];
            2'd2:    sq_src = mag_reg[2][30:0];
            default: sq_src = '0;
        endcase
    end

    // Dividend setup and one restoring step per lane.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            div_num[i]   = {1'b0, mag_reg[i][30:0], 30'b0} + 62'(root_reg[31:1]);
            div_shift[i] = {part_reg[i], nlo_reg[i][30]};
            div_ge[i]    = (div_shift[i] >= divisor);
            div_sub[i]   = div_ge[i] ? (div_shift[i] - divisor) : div_shift[i];
        end
    end

    // Signed results, zero when the vector was all zero.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            unit_out[i] = neg_reg[i] ? -$signed({1'b0, quo_reg[i]})
                                     : $signed({1'b0, quo_reg[i]});
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                        state_reg <= ST_SHIFT;
                end
                ST_SHIFT:
                begin
                    priority if (mag_or == '0)
                        state_reg <= ST_DONE;
                    else if ((|mag_or[63:31]) || (mag_or[63:30] == '0))
                        state_reg <= ST_SHIFT;
                    else
                    begin
                        state_reg <= ST_SQUARE;
                        cnt_reg   <= '0;
                    end
                end
                ST_SQUARE:
                begin
                    if (cnt_reg == 5'd3)
                        state_reg <= ST_ROOT;
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                ST_ROOT:
                begin
                    if (bit_reg == '0)
                    begin
                        state_reg <= ST_DIVIDE;
                        cnt_reg   <= '0;
                    end
                end
                ST_DIVIDE:
                begin
                    if (cnt_reg == 5'd30)
                        state_reg <= ST_DONE;
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                ST_DONE:
                    state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= vec_in[i][63];
                        mag_reg[i] <= vec_in[i][63] ? 64'(-vec_in[i]) : 64'(vec_in[i]);
                    end
                end
            end
            ST_SHIFT:
            begin
                // Bring the largest magnitude into [2^30, 2^31).
                priority if (mag_or == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        quo_reg[i] <= '0;
                end
                else if (|mag_or[63:39])
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] >> 8;
                end
                else if (|mag_or[63:31])
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (mag_or[63:22] == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] << 8;
                end
                else if (mag_or[63:30] == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] << 1;
                end
                else
                    sum_reg <= '0;
            end
            ST_SQUARE:
            begin
                prod_reg <= sq_src * sq_src;
                if (cnt_reg != 5'd0)
                    sum_reg <= sum_reg + 64'(prod_reg);
                if (cnt_reg == 5'd3)
                begin
                    rem_reg  <= sum_reg + 64'(prod_reg);
                    root_reg <= '0;
                    bit_reg  <= 64'h4000_0000_0000_0000;
                end
            end
            ST_ROOT:
            begin
                if (bit_reg != '0)
                begin
                    if (rem_reg >= root_try)
                    begin
                        rem_reg  <= rem_reg - root_try;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                end
                else
                begin
                    // Dividend is m * 2^30 plus half the root, for rounding.
                    for (int i = 0; i < 3; i++)
                    begin
                        part_reg[i] <= {1'b0, div_num[i][61:31]};
                        nlo_reg[i]  <= div_num[i][30:0];
                    end
                end
            end
            ST_DIVIDE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    part_reg[i] <= div_sub[i][31:0];
                    nlo_reg[i]  <= {nlo_reg[i][29:0], 1'b0};
                    quo_reg[i]  <= {quo_reg[i][29:0], div_ge[i]};
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

[sv/vmb_back.sv]
// Back part: sequences normalizations, cross products and offsets on one multiplier.
module vmb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  vmb_pkg::job_t pop_data,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [383:0]  m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM_F_GO,
        ST_NORM_F_WAIT,
        ST_CROSS_S,
        ST_NORM_S_GO,
        ST_NORM_S_WAIT,
        ST_CROSS_U,
        ST_OFFSET,
        ST_STORE
    } state_t;

    state_t                state_reg;
    logic [1:0]            grp_reg;
    logic [1:0]            sub_reg;
    logic                  issue_done_reg;
    logic                  p_valid_reg;
    logic                  p_neg_reg;
    logic                  p_last_reg;
    logic [1:0]            p_grp_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic signed [63:0]    prod_reg;
    vmb_pkg::acc_t         acc_reg;
    vmb_pkg::job_t         job_reg;
    vmb_pkg::vec_t         fwd_reg;
    vmb_pkg::vec_t         side_reg;
    vmb_pkg::vec_t         up_reg;
    vmb_pkg::wvec_t        side_raw_reg;
    vmb_pkg::word_t        off_reg [3];
    logic [383:0]          out_reg;

    logic                  norm_start;
    logic                  norm_done;
    vmb_pkg::wvec_t        norm_vec;
    vmb_pkg::vec_t         norm_out;
    vmb_pkg::vec_t         vec_a;
    vmb_pkg::vec_t         vec_b;
    logic [1:0]            idx_a;
    logic [1:0]            idx_b;
    vmb_pkg::word_t        mul_a;
    vmb_pkg::word_t        mul_b;
    logic                  mul_phase;
    logic                  last_sub;
    vmb_pkg::acc_t         prod_ext;
    vmb_pkg::acc_t         acc_sum;
    logic                  phase_end;
    logic                  store_ok;

    function automatic logic [1:0] idx_next(input logic [1:0] g);
        unique case (g)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] idx_prev(input logic [1:0] g);
        unique case (g)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    vmb_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (norm_start),
        .vec_in   (norm_vec),
        .done     (norm_done),
        .unit_out (norm_out)
    );

    assign pop       = (state_reg == ST_IDLE) && q_valid;
    assign norm_start = (state_reg == ST_NORM_F_GO) || (state_reg == ST_NORM_S_GO);
    assign mul_phase = (state_reg == ST_CROSS_S) || (state_reg == ST_CROSS_U)
                    || (state_reg == ST_OFFSET);
    assign last_sub  = (state_reg == ST_OFFSET) ? (sub_reg == 2'd2) : (sub_reg == 2'd1);
    assign prod_ext  = prod_reg;
    assign acc_sum   = p_neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
    assign phase_end = p_valid_reg && p_last_reg && (p_grp_reg == 2'd2);
    assign store_ok  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    // Vector handed to the normalize unit.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            norm_vec[i] = (state_reg == ST_NORM_F_GO) ? 64'(job_reg.diff[i]) : side_raw_reg[i];
    end

    // Operand selection: cross products take rotated entries, offsets a plain dot.
    always_comb
    begin
        unique case (state_reg)
            ST_CROSS_S:
            begin
                vec_a = job_reg.hint;
                vec_b = fwd_reg;
            end
            ST_CROSS_U:
            begin
                vec_a = fwd_reg;
                vec_b = side_reg;
            end
            default:
            begin
                unique case (grp_reg)
                    2'd0:    vec_a = side_reg;
                    2'd1:    vec_a = up_reg;
                    default: vec_a = fwd_reg;
                endcase
                vec_b = job_reg.eye;
            end
        endcase
        if (state_reg == ST_OFFSET)
        begin
            idx_a = sub_reg;
            idx_b = sub_reg;
        end
        else if (sub_reg == 2'd0)
        begin
            idx_a = idx_next(grp_reg);
            idx_b = idx_prev(grp_reg);
        end
        else
        begin
            idx_a = idx_prev(grp_reg);
            idx_b = idx_next(grp_reg);
        end
        mul_a = $signed(vec_a[idx_a]);
        mul_b = $signed(vec_b[idx_b]);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_STORE && store_ok)
            out_valid_next = 1'b1;
        else if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
    end

    // Sequencer and product issue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            grp_reg        <= '0;
            sub_reg        <= '0;
            issue_done_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
            p_neg_reg      <= 1'b0;
            p_last_reg     <= 1'b0;
            p_grp_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;

            if (mul_phase && !issue_done_reg)
            begin
                p_valid_reg <= 1'b1;
                p_neg_reg   <= (state_reg == ST_OFFSET) || sub_reg[0];
                p_last_reg  <= last_sub;
                p_grp_reg   <= grp_reg;
                if (last_sub)
                begin
                    sub_reg <= '0;
                    if (grp_reg == 2'd2)
                        issue_done_reg <= 1'b1;
                    else
                        grp_reg <= grp_reg + 2'd1;
                end
                else
                    sub_reg <= sub_reg + 2'd1;
            end
            else
                p_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                        state_reg <= pop_data.degenerate ? ST_STORE : ST_NORM_F_GO;
                end
                ST_NORM_F_GO:
                    state_reg <= ST_NORM_F_WAIT;
                ST_NORM_F_WAIT:
                begin
                    if (norm_done)
                        state_reg <= ST_CROSS_S;
                end
                ST_NORM_S_GO:
                    state_reg <= ST_NORM_S_WAIT;
                ST_NORM_S_WAIT:
                begin
                    if (norm_done)
                        state_reg <= ST_CROSS_U;
                end
                ST_CROSS_S, ST_CROSS_U, ST_OFFSET:
                begin
                    if (phase_end)
                    begin
                        issue_done_reg <= 1'b0;
                        grp_reg        <= '0;
                        sub_reg        <= '0;
                        priority if (state_reg == ST_CROSS_S)
                            state_reg <= ST_NORM_S_GO;
                        else if (state_reg == ST_CROSS_U)
                            state_reg <= ST_OFFSET;
                        else
                            state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    if (store_ok)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= pop_data;
            acc_reg <= '0;
            if (pop_data.degenerate)
            begin
                fwd_reg  <= '0;
                side_reg <= '0;
                up_reg   <= '0;
                for (int i = 0; i < 3; i++)
                    off_reg[i] <= '0;
            end
        end

        if (state_reg == ST_NORM_F_WAIT && norm_done)
            fwd_reg <= norm_out;
        if (state_reg == ST_NORM_S_WAIT && norm_done)
            side_reg <= norm_out;

        if (mul_phase && !issue_done_reg)
            prod_reg <= mul_a * mul_b;

        // Accumulate each product and retire a finished group.
        if (p_valid_reg)
        begin
            if (p_last_reg)
            begin
                acc_reg <= '0;
                unique case (state_reg)
                    ST_CROSS_S: side_raw_reg[p_grp_reg] <= acc_sum[63:0];
                    ST_CROSS_U: up_reg[p_grp_reg]       <= vmb_pkg::round_sat(acc_sum);
                    default:    off_reg[p_grp_reg]      <= vmb_pkg::round_sat(acc_sum);
                endcase
            end
            else
                acc_reg <= acc_sum;
        end

        if (state_reg == ST_STORE && store_ok)
            out_reg <= {off_reg[2], fwd_reg[2], fwd_reg[1], fwd_reg[0],
                        off_reg[1], up_reg[2], up_reg[1], up_reg[0],
                        off_reg[0], side_reg[2], side_reg[1], side_reg[0]};
    end

endmodule

[sv/view_matrix_builder_unit.sv]
// The normalize unit runs twice per request that is not degenerate (scaling, a bit-serial
// root, a restoring divide), and the single multiplier forms the 21 products of the cross
// products and offsets. The back part works on one request at a time; a request with eye
// equal to target skips the normalizations and products and gives an all-zero result.
// A two-entry queue and the output register let input and output stall on their own.
// Reset: asynchronous, active low; clears all control state, no clearing pass.
module view_matrix_builder_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, hint_x, hint_y, hint_z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // side_x, side_y, side_z, side_offset, upward_x, upward_y, upward_z,
    // upward_offset, fwd_x, fwd_y, fwd_z, fwd_offset
    output logic [383:0] m_tdata
);

    logic          push;
    logic          q_ready;
    logic          pop;
    logic          q_valid;
    vmb_pkg::job_t push_data;
    vmb_pkg::job_t pop_data;

    vmb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready)
    );

    vmb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_data  (pop_data)
    );

    vmb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[sv/vmb_checker.sv]
// Port-level checks for the view matrix builder and their binding to the top level.
module vmb_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [383:0] m_tdata
);

    // A result that waits stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // A result that waits keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result request changed while stalled");

    // Nothing is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

    // Forward axis entries are normalized, so none exceeds one in magnitude.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[287:256]) <= 32'sd1073741824)
                  && ($signed(m_tdata[287:256]) >= -32'sd1073741824)
                  && ($signed(m_tdata[319:288]) <= 32'sd1073741824)
                  && ($signed(m_tdata[319:288]) >= -32'sd1073741824)
                  && ($signed(m_tdata[351:320]) <= 32'sd1073741824)
                  && ($signed(m_tdata[351:320]) >= -32'sd1073741824))
        else $error("forward axis entry out of unit range");

endmodule

bind view_matrix_builder_unit vmb_checker u_vmb_checker (.*);
